### hdl/alil_pkg.sv
// Shared types and constants for the arc-length inverse lookup.
`default_nettype none
package alil_pkg;

	typedef struct packed {
		logic        req_type;
		logic [7:0]  entry_index;
		logic [30:0] entry_arc_length;
		logic [23:0] entry_parameter;
		logic signed [31:0] query_distance;
	} req_t;

	typedef struct packed {
		logic [23:0] curve_parameter;
		logic [2:0]  lookup_status;
	} res_t;

	typedef enum logic [1:0] {
		CL_WRITE,
		CL_EMPTY,
		CL_LOW,
		CL_SEARCH
	} cls_t;

	typedef struct packed {
		cls_t cls;
		req_t req;
	} qitem_t;

	localparam logic REQ_WRITE = 1'b0;

	localparam logic [2:0] ST_INTERP = 3'd0;
	localparam logic [2:0] ST_LOW    = 3'd1;
	localparam logic [2:0] ST_HIGH   = 3'd2;
	localparam logic [2:0] ST_EMPTY  = 3'd3;
	localparam logic [2:0] ST_WRITE  = 3'd4;

	localparam int ARC_W = 31;
	localparam int PAR_W = 24;
	localparam int QUO_W = 24;

endpackage
`default_nettype wire

### hdl/alil_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module alil_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [W-1:0]             wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [W-1:0]             rdata
);
	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

### hdl/alil_front.sv
// Front end: takes requests, classifies them and queues them for the back end.
`default_nettype none
module alil_front import alil_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	output logic        busy,
	input  wire req_t   req,
	input  wire logic   tbl_empty,
	output logic        q_valid,
	output qitem_t      q_item,
	input  wire logic   q_pop
);
	qitem_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	cls_t       cls;

	always_comb begin
		if (req.req_type == REQ_WRITE) begin
			cls = CL_WRITE;
		end else if (tbl_empty) begin
			cls = CL_EMPTY;
		end else if (req.query_distance[31] || req.query_distance == 32'sd0) begin
			cls = CL_LOW;
		end else begin
			cls = CL_SEARCH;
		end
	end

	assign busy    = (count_q == 2'd2);
	assign push    = start && !busy;
	assign q_valid = (count_q != 2'd0);
	assign q_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{cls: cls, req: req};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n) count_q <= 2'd2)
		else $error("queue overfilled");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> count_q != 2'd0)
		else $error("pop from empty queue");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2 && !q_pop) |=> count_q == 2'd2)
		else $error("full queue changed without pop");
endmodule
`default_nettype wire

### hdl/alil_back.sv
// Back end: table writes, binary search, interpolation and iterative divide.
`default_nettype none
module alil_back import alil_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire qitem_t                       q_item,
	output logic                              q_pop,
	input  wire logic [$clog2(TABLE_DEPTH):0] n,
	output logic                              done,
	output res_t                              result
);
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int NW = IW + 1;
	localparam int RW = ARC_W + PAR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_LAST, S_SRCH, S_HI, S_LO, S_MUL, S_DIVSET, S_DIV, S_FIN
	} state_t;

	state_t              state_q;
	logic                wait_q;
	qitem_t              item_q;
	logic [NW-1:0]       lo_q, hi_q;
	logic [IW-1:0]       mid_q, idx_q;
	logic [ARC_W-1:0]    a1_q, a0_q;
	logic [PAR_W-1:0]    p1_q, p0_q;
	logic [30:0]         seg_q;
	logic signed [57:0]  num_q;
	logic                neg_q;
	logic [31:0]         rem_q;
	logic [QUO_W-1:0]    nlow_q, quo_q;
	logic [4:0]          cnt_q;
	logic                done_q;
	res_t                res_q;
	logic [IW-1:0]       raddr_q, waddr_q;
	logic                we_q;
	logic [RW-1:0]       wdata_q;
	logic [RW-1:0]       rdata;

	logic [ARC_W-1:0]    rd_arc;
	logic [PAR_W-1:0]    rd_par;
	logic [31:0]         dist_u;
	logic                a_lt_d;
	logic [NW-1:0]       lo_nx, hi_nx;
	logic [NW:0]         mid_sum;
	logic [IW-1:0]       n_last;
	logic [31:0]         ix32;
	logic signed [24:0]  dp;
	logic signed [32:0]  dd;
	logic [57:0]         mag;
	logic [32:0]         rem_sh;
	logic                ge;
	logic [32:0]         rem_sub;
	logic signed [25:0]  qs, fin;
	logic [PAR_W-1:0]    fin_c;

	alil_ram #(.W(RW), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we_q),
		.waddr (waddr_q),
		.wdata (wdata_q),
		.raddr (raddr_q),
		.rdata (rdata)
	);

	always_comb begin
		rd_arc  = rdata[RW-1:PAR_W];
		rd_par  = rdata[PAR_W-1:0];
		dist_u  = $unsigned(item_q.req.query_distance);
		a_lt_d  = {1'b0, rd_arc} < dist_u;
		if (a_lt_d) begin
			lo_nx = NW'(mid_q) + NW'(1);
			hi_nx = hi_q;
		end else begin
			lo_nx = lo_q;
			hi_nx = NW'(mid_q);
		end
		mid_sum = ((NW+1)'(lo_nx) + (NW+1)'(hi_nx)) >> 1;
		n_last  = IW'(n - NW'(1));
		ix32    = 32'(q_item.req.entry_index);
		dp      = $signed({1'b0, p1_q}) - $signed({1'b0, p0_q});
		dd      = $signed({1'b0, dist_u}) - $signed({2'b0, a0_q});
		mag     = num_q[57] ? 58'(-num_q) : 58'(num_q);
		rem_sh  = {rem_q, nlow_q[QUO_W-1]};
		ge      = rem_sh >= {2'b0, seg_q};
		rem_sub = rem_sh - {2'b0, seg_q};
		qs      = neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
		fin     = $signed({2'b0, p0_q}) + qs;
		if (fin < 26'sd0) begin
			fin_c = '0;
		end else if (fin > $signed({2'b0, {PAR_W{1'b1}}})) begin
			fin_c = '1;
		end else begin
			fin_c = fin[PAR_W-1:0];
		end
	end

	assign q_pop  = (state_q == S_IDLE) && q_valid;
	assign done   = done_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= 1'b0;
			done_q  <= 1'b0;
			we_q    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			we_q   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						unique case (q_item.cls)
							CL_WRITE: begin
								we_q    <= ix32 < 32'(TABLE_DEPTH);
								waddr_q <= ix32[IW-1:0];
								wdata_q <= {q_item.req.entry_arc_length,
									q_item.req.entry_parameter};
								done_q  <= 1'b1;
								res_q   <= '{curve_parameter: '0, lookup_status: ST_WRITE};
							end
							CL_EMPTY: begin
								done_q <= 1'b1;
								res_q  <= '{curve_parameter: '0, lookup_status: ST_EMPTY};
							end
							CL_LOW: begin
								raddr_q <= '0;
								wait_q  <= 1'b1;
								state_q <= S_FIRST;
							end
							CL_SEARCH: begin
								raddr_q <= n_last;
								wait_q  <= 1'b1;
								state_q <= S_LAST;
							end
							default: ;
						endcase
					end
				end
				S_FIRST: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{curve_parameter: rd_par, lookup_status: ST_LOW};
						state_q <= S_IDLE;
					end
				end
				S_LAST: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else if (!a_lt_d && {1'b0, rd_arc} != dist_u) begin
						lo_q    <= '0;
						hi_q    <= n;
						mid_q   <= IW'(n >> 1);
						raddr_q <= IW'(n >> 1);
						wait_q  <= 1'b1;
						state_q <= S_SRCH;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{curve_parameter: rd_par, lookup_status: ST_HIGH};
						state_q <= S_IDLE;
					end
				end
				S_SRCH: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						lo_q <= lo_nx;
						hi_q <= hi_nx;
						if (lo_nx < hi_nx) begin
							mid_q   <= mid_sum[IW-1:0];
							raddr_q <= mid_sum[IW-1:0];
							wait_q  <= 1'b1;
						end else if (lo_nx == '0 || lo_nx >= n) begin
							raddr_q <= '0;
							wait_q  <= 1'b1;
							state_q <= S_FIRST;
						end else begin
							idx_q   <= lo_nx[IW-1:0];
							raddr_q <= lo_nx[IW-1:0];
							wait_q  <= 1'b1;
							state_q <= S_HI;
						end
					end
				end
				S_HI: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						a1_q    <= rd_arc;
						p1_q    <= rd_par;
						raddr_q <= idx_q - IW'(1);
						wait_q  <= 1'b1;
						state_q <= S_LO;
					end
				end
				S_LO: begin
					if (wait_q) begin
						wait_q <= 1'b0;
					end else begin
						a0_q    <= rd_arc;
						p0_q    <= rd_par;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					num_q   <= dp * dd;
					seg_q   <= a1_q - a0_q;
					state_q <= S_DIVSET;
				end
				S_DIVSET: begin
					if (seg_q == '0) begin
						done_q  <= 1'b1;
						res_q   <= '{curve_parameter: p0_q, lookup_status: ST_INTERP};
						state_q <= S_IDLE;
					end else begin
						neg_q   <= num_q[57];
						rem_q   <= mag[55:24];
						nlow_q  <= mag[23:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q  <= ge ? rem_sub[31:0] : rem_sh[31:0];
					nlow_q <= {nlow_q[QUO_W-2:0], 1'b0};
					quo_q  <= {quo_q[QUO_W-2:0], ge};
					cnt_q  <= cnt_q + 5'd1;
					if (cnt_q == 5'(QUO_W - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					res_q   <= '{curve_parameter: fin_c, lookup_status: ST_INTERP};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we_q |-> $past(state_q == S_IDLE))
		else $error("table write outside idle");
	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH && !wait_q) |-> lo_q < hi_q)
		else $error("search bounds crossed");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < 5'(QUO_W))
		else $error("divide overran");
	a_pop_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> !(state_q == S_IDLE && $past(q_item.cls == CL_LOW ||
			q_item.cls == CL_SEARCH)))
		else $error("query dispatch lost");
endmodule
`default_nettype wire

### hdl/arc_length_inverse_lookup.sv
// Top level of the arc-length to curve-parameter lookup.
`default_nettype none
// A request is taken when start is high and busy is low; a two-entry queue
// sits between request intake and execution, so busy rises only when both
// entries wait. Every request yields one result, shown for one cycle with
// done high; the receiver cannot stall it. Writes and empty-table answers
// are decided as soon as the back end takes them from the queue; clamps
// decided without a search need one table read, and an interpolated query
// reads the last entry, runs a binary search over the n entries in use,
// reads the two neighbouring entries, multiplies and, unless the segment is
// zero, runs a 24-step bit-serial divide. entries_in_use is written through
// cfg_we/cfg_wdata; the user must do so only while no request is in flight, as the block itself does not enforce it.
module arc_length_inverse_lookup import alil_pkg::*; #(
	parameter int TABLE_DEPTH = 256
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire req_t       req,
	output logic            done,
	output res_t            result,
	input  wire logic       cfg_we,
	input  wire logic [8:0] cfg_wdata
);
	localparam int NW = $clog2(TABLE_DEPTH) + 1;
	localparam int CW = (NW > 9) ? NW : 9;

	logic [8:0]    entries_q;
	logic [NW-1:0] n_sat;
	logic          q_valid;
	logic          q_pop;
	qitem_t        q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
		end else if (cfg_we) begin
			entries_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (CW'(entries_q) > CW'(TABLE_DEPTH)) begin
			n_sat = NW'(TABLE_DEPTH);
		end else begin
			n_sat = NW'(entries_q);
		end
	end

	alil_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.tbl_empty (entries_q == '0),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	alil_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.n       (n_sat),
		.done    (done),
		.result  (result)
	);
endmodule
`default_nettype wire

### tb/tb_arc_length_inverse_lookup.sv
// Self-checking testbench for the arc-length to curve-parameter lookup.
`timescale 1ns / 1ps
module tb_arc_length_inverse_lookup;
	import alil_pkg::*;

	class lookup_scoreboard;
		logic [30:0] arc_tbl [256];
		logic [23:0] par_tbl [256];
		int unsigned entries;
		res_t pending [$];
		int errors;
		int checked;

		function new();
			entries = 0;
			errors = 0;
			checked = 0;
		endfunction

		function void set_entries(logic [8:0] v);
			entries = (v > 256) ? 256 : v;
		endfunction

		function res_t lookup(req_t r);
			res_t o;
			longint d, d0, d1, p0, p1, seg;
			int unsigned lo, hi, mid, n;
			o.curve_parameter = '0;
			n = entries;
			if (r.req_type == REQ_WRITE) begin
				arc_tbl[r.entry_index] = r.entry_arc_length;
				par_tbl[r.entry_index] = r.entry_parameter;
				o.lookup_status = ST_WRITE;
				return o;
			end
			if (n == 0) begin
				o.lookup_status = ST_EMPTY;
				return o;
			end
			d = longint'(r.query_distance);
			if (d <= 0) begin
				o.curve_parameter = par_tbl[0];
				o.lookup_status = ST_LOW;
				return o;
			end
			if (d >= longint'(arc_tbl[n-1])) begin
				o.curve_parameter = par_tbl[n-1];
				o.lookup_status = ST_HIGH;
				return o;
			end
			lo = 0;
			hi = n;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (longint'(arc_tbl[mid]) < d) lo = mid + 1;
				else hi = mid;
			end
			if (lo == 0 || lo >= n) begin
				o.curve_parameter = par_tbl[0];
				o.lookup_status = ST_LOW;
				return o;
			end
			d0 = arc_tbl[lo-1];
			d1 = arc_tbl[lo];
			p0 = par_tbl[lo-1];
			p1 = par_tbl[lo];
			seg = d1 - d0;
			o.lookup_status = ST_INTERP;
			if (seg > 0) p0 = p0 + ((p1 - p0) * (d - d0)) / seg;
			if (p0 < 0) p0 = 0;
			if (p0 > 24'hFFFFFF) p0 = 24'hFFFFFF;
			o.curve_parameter = p0[23:0];
			return o;
		endfunction

		function void note_request(req_t r);
			pending.push_back(lookup(r));
		endfunction

		function void check_result(res_t got);
			res_t exp;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected result param=%h status=%0d", $time,
					got.curve_parameter, got.lookup_status);
				return;
			end
			exp = pending.pop_front();
			if (got.curve_parameter !== exp.curve_parameter) begin
				errors++;
				$display("%0t curve_parameter exp %h got %h", $time,
					exp.curve_parameter, got.curve_parameter);
			end
			if (got.lookup_status !== exp.lookup_status) begin
				errors++;
				$display("%0t lookup_status exp %0d got %0d", $time,
					exp.lookup_status, got.lookup_status);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	req_t req = '0;
	logic done;
	res_t result;
	logic cfg_we = 0;
	logic [8:0] cfg_wdata = '0;

	lookup_scoreboard sb = new();
	int idle_pct = 0;
	int sent = 0;
	int quiet = 0;
	bit written [256];
	int filled = 0;

	arc_length_inverse_lookup dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (done) sb.check_result(result);
		if ((start && !busy) || done) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// start stays high from one transfer to the next unless the sender idles
	task automatic send(req_t r);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_request(r);
		if (r.req_type == REQ_WRITE) written[r.entry_index] = 1;
		sent++;
	endtask

	task automatic drain();
		start <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_count(logic [8:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_entries(v);
		@(posedge clk);
	endtask

	task automatic write_entry(int ix, logic [30:0] a, logic [23:0] p);
		req_t r;
		r = '0;
		r.req_type = REQ_WRITE;
		r.entry_index = 8'(ix);
		r.entry_arc_length = a;
		r.entry_parameter = p;
		r.query_distance = $urandom;
		send(r);
	endtask

	task automatic query(logic signed [31:0] q);
		req_t r;
		r = '0;
		r.req_type = ~REQ_WRITE;
		r.entry_index = 8'($urandom);
		r.entry_arc_length = 31'($urandom);
		r.entry_parameter = 24'($urandom);
		r.query_distance = q;
		send(r);
	endtask

	// rising table of n entries starting at entry 0, random spacing
	task automatic load_table(int n, int unsigned step_max);
		logic [30:0] a;
		a = 31'($urandom_range(step_max));
		for (int i = 0; i < n; i++) begin
			write_entry(i, a, 24'($urandom));
			a = 31'(a + $urandom_range(step_max) + 1);
		end
	endtask

	function automatic int unsigned valid_count(int unsigned want);
		int unsigned k;
		k = 0;
		while (k < want && written[k]) k++;
		return k;
	endfunction

	initial begin
		logic [8:0] n;
		int unsigned lim;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, writes at extremes, clamps, interpolation
		query(32'sh7FFFFFFF);
		query(32'sh80000000);
		write_entry(0, 31'd0, 24'd0);
		write_entry(255, 31'h7FFFFFFF, 24'hFFFFFF);
		write_entry(1, 31'h00010000, 24'hFFFFFF);
		write_entry(2, 31'h00030000, 24'h000100);
		write_entry(3, 31'h00030000, 24'h123456);
		set_count(9'd1);
		query(0);
		query(32'sh7FFFFFFF);
		set_count(9'd4);
		query(-1);
		query(32'sh00008000);
		query(32'sh00020000);
		query(32'sh00010000);
		query(32'sh00030000);
		query(32'sh0002FFFF);
		query(1);
		set_count(9'd511);
		query(32'sh7FFFFFFF);
		query(0);

		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 54;
				2: idle_pct = 12;
				default: idle_pct = 54;
			endcase
			set_count(9'd0);
			lim = (ph % 5 == 4 || ph == 3) ? 256 : $urandom_range(2, 12);
			load_table(lim, (ph % 3 == 0) ? 31'h7FFFFF : 31'h3FFFF);
			if (ph == 7) begin
				// scramble some entries so the search sees an unsorted table
				for (int i = 0; i < 4; i++)
					write_entry($urandom_range(lim - 1), 31'($urandom), 24'($urandom));
			end
			n = (ph == 3) ? 9'd300 : 9'(valid_count(lim));
			set_count(n);
			lim = (ph == 3) ? 256 : n;
			for (int k = 0; k < 35; k++) begin
				case ($urandom_range(9))
					0: query($urandom);
					1: query(-$urandom_range(1000));
					2: write_entry((lim < 256) ? lim + $urandom_range(255 - lim)
						: $urandom_range(255), 31'($urandom), 24'($urandom));
					default: query(32'(sb.arc_tbl[lim-1] * 64'($urandom_range(1100)) / 1000));
				endcase
			end
		end
		drain();
		$display("Covered %0d requests, %0d results checked, table sizes 0 to 256,",
			sent, sb.checked);
		$display("clamps, writes and interpolation under several idle patterns.");
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

### sim.f
hdl/alil_pkg.sv
hdl/alil_ram.sv
hdl/alil_front.sv
hdl/alil_back.sv
hdl/arc_length_inverse_lookup.sv
tb/tb_arc_length_inverse_lookup.sv
